>>> rtl/core/twdp_pkg.sv
package twdp_pkg;

  localparam int ACT_W     = 16;
  localparam int FRAC_W    = 14;
  localparam int ACC_W     = 48;
  localparam int SCALE_W   = 16;
  localparam int BLOCK_W   = 28;
  localparam int OUT_W     = 48;
  localparam int NUM_TRITS = 5;
  localparam int BSUM_W    = ACT_W + 4;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] FMT_TQ1 = 2'd0;
  localparam logic [1:0] FMT_TQ2 = 2'd1;
  localparam logic [1:0] FMT_I2S = 2'd2;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_TSCALE = 1'b1;

  typedef struct packed {
    logic signed [BSUM_W-1:0]  byte_sum;
    logic signed [SCALE_W-1:0] block_scale;
    logic                      block_end;
    logic                      row_end;
    logic                      unscaled;
  } entry_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] row_value;
    logic                    saturated;
  } result_t;

endpackage

>>> rtl/core/twdp_front.sv
module twdp_front (
  input  logic [1:0]                       weight_format_i,
  input  logic [7:0]                       weight_byte_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_i [twdp_pkg::NUM_TRITS],
  input  logic                             high_part_byte_i,
  input  logic signed [15:0]               block_scale_i,
  input  logic                             block_end_i,
  input  logic                             row_end_i,
  output twdp_pkg::entry_t                 entry_o
);
  import twdp_pkg::*;

  localparam logic [7:0] POW3 [6] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81, 8'd243};
  localparam logic signed [2:0] I2S_MAP [4] = '{-3'sd1, 3'sd0, 3'sd1, 3'sd0};

  logic signed [2:0]       trit [NUM_TRITS];
  logic signed [ACT_W+1:0] prod [NUM_TRITS];
  logic signed [BSUM_W-1:0] sum;

  always_comb begin
    logic [7:0] q;
    logic [9:0] q3;
    for (int n = 0; n < NUM_TRITS; n++) begin
      trit[n] = '0;
    end
    q  = '0;
    q3 = '0;
    case (weight_format_i)
      FMT_TQ1: begin
        for (int n = 0; n < NUM_TRITS; n++) begin
          if (n < NUM_TRITS - 1 || !high_part_byte_i) begin
            q       = 8'(weight_byte_i * POW3[n]);
            q3      = 10'(q) * 10'd3;
            trit[n] = $signed({1'b0, q3[9:8]}) - 3'sd1;
          end
        end
      end
      FMT_TQ2: begin
        for (int n = 0; n < NUM_TRITS - 1; n++) begin
          trit[n] = $signed({1'b0, weight_byte_i[2*n +: 2]}) - 3'sd1;
        end
      end
      FMT_I2S: begin
        for (int n = 0; n < NUM_TRITS - 1; n++) begin
          trit[n] = I2S_MAP[weight_byte_i[6-2*n +: 2]];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sum = '0;
    for (int n = 0; n < NUM_TRITS; n++) begin
      case (trit[n])
        -3'sd1:  prod[n] = -(ACT_W+2)'(act_i[n]);
        3'sd1:   prod[n] = (ACT_W+2)'(act_i[n]);
        3'sd2:   prod[n] = (ACT_W+2)'(act_i[n]) <<< 1;
        default: prod[n] = '0;
      endcase
      sum = sum + BSUM_W'(prod[n]);
    end
  end

  always_comb begin
    entry_o.byte_sum    = sum;
    entry_o.block_scale = block_scale_i;
    entry_o.block_end   = block_end_i | row_end_i;
    entry_o.row_end     = row_end_i;
    entry_o.unscaled    = (weight_format_i == FMT_I2S);
  end

endmodule

>>> rtl/core/twdp_queue.sv
module twdp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  twdp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output twdp_pkg::entry_t head_o,
  output logic             empty_o
);
  import twdp_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/core/twdp_back.sv
module twdp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  twdp_pkg::entry_t             head_i,
  input  logic                         head_empty_i,
  output logic                         head_pop_o,
  input  logic signed [twdp_pkg::SCALE_W-1:0] tscale_i,
  output logic                         res_valid_o,
  output twdp_pkg::result_t            res_o,
  input  logic                         res_pop_i
);
  import twdp_pkg::*;

  localparam int BADD_W = ((BSUM_W > BLOCK_W) ? BSUM_W : BLOCK_W) + 1;
  localparam int PB_W   = BLOCK_W + SCALE_W;
  localparam int SHB_W  = PB_W - FRAC_W;
  localparam int EXB_W  = (SHB_W > ACC_W) ? SHB_W : ACC_W;
  localparam int RADD_W = ACC_W + 1;
  localparam int PT_W   = ACC_W + SCALE_W;
  localparam int SHT_W  = PT_W - FRAC_W;

  typedef enum logic [5:0] {
    S_ACC  = 6'b000001,
    S_BMUL = 6'b000010,
    S_BSCL = 6'b000100,
    S_ROW  = 6'b001000,
    S_TMUL = 6'b010000,
    S_TSCL = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic signed [BLOCK_W-1:0]  block_sum_q, block_sum_d;
  logic signed [ACC_W-1:0]    row_sum_q, row_sum_d;
  logic                       ov_q, ov_d;
  logic signed [SCALE_W-1:0]  bscale_q, bscale_d;
  logic                       rend_q, rend_d;
  logic signed [ACC_W-1:0]    scaled_q, scaled_d;
  logic signed [PB_W-1:0]     bprod_q, bprod_d;
  logic signed [PT_W-1:0]     tprod_q, tprod_d;
  logic                       out_valid_q, out_valid_d;
  result_t                    out_q, out_d;

  logic signed [BADD_W-1:0]   bsum_ext;
  logic                       bsum_fit;
  logic signed [BLOCK_W-1:0]  bsum_sat;
  logic signed [EXB_W-1:0]    bscl_ext;
  logic                       bscl_fit;
  logic signed [ACC_W-1:0]    bscl_sat;
  logic signed [RADD_W-1:0]   radd_ext;
  logic                       radd_fit;
  logic signed [ACC_W-1:0]    radd_sat;
  logic signed [SHT_W-1:0]    tscl_ext;
  logic                       tscl_fit;
  logic signed [ACC_W-1:0]    tscl_sat;
  logic signed [63:0]         tscl_wide;

  assign bsum_ext = BADD_W'(block_sum_q) + BADD_W'($signed(head_i.byte_sum));
  assign bsum_fit = (&bsum_ext[BADD_W-1:BLOCK_W-1]) | ~(|bsum_ext[BADD_W-1:BLOCK_W-1]);
  assign bsum_sat = bsum_fit ? bsum_ext[BLOCK_W-1:0]
                             : {bsum_ext[BADD_W-1], {(BLOCK_W-1){~bsum_ext[BADD_W-1]}}};

  assign bscl_ext = EXB_W'($signed(bprod_q[PB_W-1:FRAC_W]));
  assign bscl_fit = (&bscl_ext[EXB_W-1:ACC_W-1]) | ~(|bscl_ext[EXB_W-1:ACC_W-1]);
  assign bscl_sat = bscl_fit ? bscl_ext[ACC_W-1:0]
                             : {bscl_ext[EXB_W-1], {(ACC_W-1){~bscl_ext[EXB_W-1]}}};

  assign radd_ext = RADD_W'(row_sum_q) + RADD_W'(scaled_q);
  assign radd_fit = (&radd_ext[RADD_W-1:ACC_W-1]) | ~(|radd_ext[RADD_W-1:ACC_W-1]);
  assign radd_sat = radd_fit ? radd_ext[ACC_W-1:0]
                             : {radd_ext[RADD_W-1], {(ACC_W-1){~radd_ext[RADD_W-1]}}};

  assign tscl_ext  = tprod_q[PT_W-1:FRAC_W];
  assign tscl_fit  = (&tscl_ext[SHT_W-1:ACC_W-1]) | ~(|tscl_ext[SHT_W-1:ACC_W-1]);
  assign tscl_sat  = tscl_fit ? tscl_ext[ACC_W-1:0]
                              : {tscl_ext[SHT_W-1], {(ACC_W-1){~tscl_ext[SHT_W-1]}}};
  assign tscl_wide = 64'(tscl_sat);

  assign head_pop_o  = (state_q == S_ACC) && !head_empty_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    block_sum_d = block_sum_q;
    row_sum_d   = row_sum_q;
    ov_d        = ov_q;
    bscale_d    = bscale_q;
    rend_d      = rend_q;
    scaled_d    = scaled_q;
    bprod_d     = bprod_q;
    tprod_d     = tprod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_pop_i;
    case (state_q)
      S_ACC: begin
        if (!head_empty_i) begin
          block_sum_d = bsum_sat;
          ov_d        = ov_q | ~bsum_fit;
          bscale_d    = head_i.block_scale;
          rend_d      = head_i.row_end;
          if (head_i.block_end) begin
            if (head_i.unscaled) begin
              scaled_d = ACC_W'(bsum_sat);
              state_d  = S_ROW;
            end else begin
              state_d = S_BMUL;
            end
          end
        end
      end
      S_BMUL: begin
        bprod_d = block_sum_q * bscale_q;
        state_d = S_BSCL;
      end
      S_BSCL: begin
        scaled_d = bscl_sat;
        ov_d     = ov_q | ~bscl_fit;
        state_d  = S_ROW;
      end
      S_ROW: begin
        row_sum_d   = radd_sat;
        ov_d        = ov_q | ~radd_fit;
        block_sum_d = '0;
        state_d     = rend_q ? S_TMUL : S_ACC;
      end
      S_TMUL: begin
        tprod_d = row_sum_q * tscale_i;
        state_d = S_TSCL;
      end
      S_TSCL: begin
        if (!out_valid_q || res_pop_i) begin
          out_d.row_value = tscl_wide[OUT_W-1:0];
          out_d.saturated = ov_q | ~tscl_fit;
          out_valid_d     = 1'b1;
          row_sum_d       = '0;
          ov_d            = 1'b0;
          state_d         = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bscale_q <= bscale_d;
    rend_q   <= rend_d;
    scaled_q <= scaled_d;
    bprod_q  <= bprod_d;
    tprod_q  <= tprod_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      block_sum_q <= '0;
      row_sum_q   <= '0;
      ov_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      block_sum_q <= block_sum_d;
      row_sum_q   <= row_sum_d;
      ov_q        <= ov_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/ternary_weight_dot_product_core.sv
// Ternary-weight dot product core.
// Input channel: push_i/full_o. Each item is one packed weight byte with its
// activations, block scale and block/row end marks; it is decoded into trit
// products on entry and held in a two-entry queue.
// Result channel: empty_o/pop_i. One result (row value and saturation flag)
// per row end, held in an output register until popped.
// Configuration: APB write/read of weight_format (0x0) and the per-tensor scale
// (0x4), to be changed only while the core is idle.
// Throughput: one item per cycle for bytes inside a block, set by the block
// accumulator, while the back end waits in its accumulate state. A block end
// adds block scale multiply, shift/saturate and row add steps, or only the row
// add in I2_S format. A row end adds tensor scale multiply and shift/saturate.
// A stalled receiver holds the result register; the back end then stops at
// the next row end and the queue fills, raising full_o.
// Reset clears accumulators, the queue and the result valid flag and sets the
// format to TQ1_0 and the tensor scale to 1.0.
module ternary_weight_dot_product_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [7:0]                       weight_byte_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_a_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_b_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_c_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_d_i,
  input  logic signed [twdp_pkg::ACT_W-1:0] act_e_i,
  input  logic                             high_part_byte_i,
  input  logic signed [15:0]               block_scale_i,
  input  logic                             block_end_i,
  input  logic                             row_end_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic signed [47:0]               row_value_o,
  output logic                             saturated_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import twdp_pkg::*;

  logic [1:0]                fmt_q;
  logic signed [SCALE_W-1:0] tscale_q;
  logic                      cfg_wr;
  logic signed [ACT_W-1:0]   acts [NUM_TRITS];
  entry_t                    entry, head;
  logic                      q_full, q_empty, q_pop, res_valid;
  result_t                   res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_TQ1;
      tscale_q <= 16'sd16384;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FORMAT: fmt_q    <= pwdata[1:0];
        REG_TSCALE: tscale_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FORMAT: prdata = {30'd0, fmt_q};
      REG_TSCALE: prdata = {16'd0, tscale_q};
      default:    prdata = '0;
    endcase
  end

  assign acts[0] = act_a_i;
  assign acts[1] = act_b_i;
  assign acts[2] = act_c_i;
  assign acts[3] = act_d_i;
  assign acts[4] = act_e_i;

  twdp_front u_front (
    .weight_format_i  (fmt_q),
    .weight_byte_i    (weight_byte_i),
    .act_i            (acts),
    .high_part_byte_i (high_part_byte_i),
    .block_scale_i    (block_scale_i),
    .block_end_i      (block_end_i),
    .row_end_i        (row_end_i),
    .entry_o          (entry)
  );

  twdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  twdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (q_empty),
    .head_pop_o   (q_pop),
    .tscale_i     (tscale_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop_i)
  );

  assign full_o      = q_full;
  assign empty_o     = !res_valid;
  assign row_value_o = res.row_value;
  assign saturated_o = res.saturated;

endmodule

>>> rtl/core/twdp_checker.sv
module twdp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             empty_o,
  input logic                             pop_i,
  input logic signed [47:0]               row_value_o,
  input logic                             saturated_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [2:0]                       paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata,
  input logic                             pready
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty_o)
    else $error("result pending during reset");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(row_value_o) && $stable(saturated_o))
    else $error("stalled result item changed");

  a_tscale_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2]
    |=> !paddr[2] || prdata[15:0] == $past(pwdata[15:0]))
    else $error("tensor scale readback mismatch");

  a_format_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !paddr[2] |-> prdata[31:2] == 30'd0)
    else $error("format register wider than two bits");

endmodule

bind ternary_weight_dot_product_core twdp_checker u_checker (.*);
